>>> src/rrsp_pkg.sv
// Shared types and constants for the RESP reply stream parser.
// Used by every module of the block but rrsp_in_stage; depends on nothing else.
`default_nettype none

package rrsp_pkg;

    // Widths of the configuration registers and the counters that follow them.
    localparam int BULK_LEN_BITS  = 24;
    localparam int COUNT_BITS     = 32;
    localparam int BULK_PROD_BITS = BULK_LEN_BITS + 4;
    localparam int ELEM_BITS      = COUNT_BITS + 1;
    localparam int ELEM_PROD_BITS = ELEM_BITS + 4;
    localparam int CFG_DATA_BITS  = (BULK_LEN_BITS > COUNT_BITS) ? BULK_LEN_BITS : COUNT_BITS;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [BULK_LEN_BITS-1:0] MAX_BULK_LEN_RESET  = BULK_LEN_BITS'(1024 * 1024);
    localparam logic [COUNT_BITS-1:0]    MAX_ARRAY_CNT_RESET = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_BULK_LEN    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ARRAY_COUNT = 1'd1;

    // Result status codes.
    localparam logic [1:0] ST_BUSY       = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_SERVER_ERR = 2'd2;
    localparam logic [1:0] ST_FAULT      = 2'd3;

    // Error kinds. The parse steps reuse them as their return codes, with
    // STEP_BUSY and STEP_DONE in the two lowest codes.
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_BAD_TYPE      = 3'd1;
    localparam logic [2:0] ERR_BULK_TOO_LONG = 3'd2;
    localparam logic [2:0] ERR_BULK_LEN_END  = 3'd3;
    localparam logic [2:0] ERR_BULK_DATA_END = 3'd4;
    localparam logic [2:0] ERR_COUNT_LARGE   = 3'd5;
    localparam logic [2:0] ERR_COUNT_END     = 3'd6;
    localparam logic [2:0] ERR_ELEM_HEADER   = 3'd7;
    localparam logic [2:0] STEP_BUSY         = 3'd0;
    localparam logic [2:0] STEP_DONE         = 3'd1;

    // Reply type codes.
    localparam logic [3:0] TYPE_NONE     = 4'd0;
    localparam logic [3:0] TYPE_ERROR    = 4'd1;
    localparam logic [3:0] TYPE_STATUS   = 4'd2;
    localparam logic [3:0] TYPE_INTEGER  = 4'd3;
    localparam logic [3:0] TYPE_DOUBLE   = 4'd4;
    localparam logic [3:0] TYPE_NULL     = 4'd5;
    localparam logic [3:0] TYPE_BULK     = 4'd6;
    localparam logic [3:0] TYPE_ARRAY    = 4'd7;
    localparam logic [3:0] TYPE_MAP      = 4'd8;
    localparam logic [3:0] TYPE_SET      = 4'd9;
    localparam logic [3:0] TYPE_BOOL     = 4'd10;
    localparam logic [3:0] TYPE_VERBATIM = 4'd11;
    localparam logic [3:0] TYPE_PUSH     = 4'd12;
    localparam logic [3:0] TYPE_BIGNUM   = 4'd13;

    typedef enum logic [1:0] {
        LINE_SEEK_CR = 2'b01,
        LINE_CR_SEEN = 2'b10
    } line_phase_t;

    typedef enum logic [4:0] {
        BULK_LEN     = 5'b00001,
        BULK_LEN_LF  = 5'b00010,
        BULK_DATA    = 5'b00100,
        BULK_DATA_CR = 5'b01000,
        BULK_DATA_LF = 5'b10000
    } bulk_phase_t;

    typedef enum logic [4:0] {
        AGG_COUNT    = 5'b00001,
        AGG_COUNT_LF = 5'b00010,
        AGG_HEADER   = 5'b00100,
        AGG_BULK     = 5'b01000,
        AGG_LINE     = 5'b10000
    } agg_phase_t;

    typedef struct packed {
        logic [BULK_LEN_BITS-1:0] max_bulk_len;
        logic [COUNT_BITS-1:0]    max_array_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  error_kind;
        logic [3:0]  reply_type;
        logic [7:0]  error_byte;
        logic [31:0] reply_count;
    } result_t;

endpackage

`default_nettype wire

>>> src/rrsp_cfg_regs.sv
// Configuration registers of the RESP reply parser: bulk length and count limits.
// Depends on rrsp_pkg.
`default_nettype none

module rrsp_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write_en,
    input  wire logic [rrsp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [rrsp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output rrsp_pkg::cfg_t                            cfg
);

    rrsp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bulk_len    <= rrsp_pkg::MAX_BULK_LEN_RESET;
            cfg_reg.max_array_count <= rrsp_pkg::MAX_ARRAY_CNT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rrsp_pkg::CFG_MAX_BULK_LEN:
                begin
                    cfg_reg.max_bulk_len <= cfg_data[rrsp_pkg::BULK_LEN_BITS-1:0];
                end
                rrsp_pkg::CFG_MAX_ARRAY_COUNT:
                begin
                    cfg_reg.max_array_count <= cfg_data[rrsp_pkg::COUNT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/rrsp_in_stage.sv
// Input register of the RESP reply parser: holds one byte until the parser takes it.
// Depends on rrsp_pkg only through the house conventions; no package items used.
`default_nettype none

module rrsp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_value,
    input  wire logic       out_free,
    output logic            take,
    output logic [7:0]      byte_out
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The held byte moves on whenever the result register can take its result.
    assign take     = valid_reg && out_free;
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_value;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

>>> src/rrsp_parse_core.sv
// Parser state and the per-byte decode logic of the RESP reply parser.
// Depends on rrsp_pkg for codes, phase encodings and the result struct.
`default_nettype none

module rrsp_parse_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] byte_in,
    input  wire rrsp_pkg::cfg_t cfg,
    output rrsp_pkg::result_t result
);

    localparam int BLB = rrsp_pkg::BULK_LEN_BITS;
    localparam int BPB = rrsp_pkg::BULK_PROD_BITS;
    localparam int ELB = rrsp_pkg::ELEM_BITS;
    localparam int EPB = rrsp_pkg::ELEM_PROD_BITS;
    localparam int CNB = rrsp_pkg::COUNT_BITS;

    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_LF     = 8'd10;
    localparam logic [7:0] CHAR_DOLLAR = 8'd36;
    localparam logic [7:0] CHAR_COLON  = 8'd58;
    localparam logic [7:0] CHAR_COMMA  = 8'd44;
    localparam logic [7:0] CHAR_UNDER  = 8'd95;
    localparam logic [7:0] CHAR_HASH   = 8'd35;
    localparam logic [7:0] CHAR_LPAREN = 8'd40;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;

    function automatic logic [3:0] decode_type(input logic [7:0] b);
        logic [3:0] t;
        unique case (b)
            8'd45:   t = rrsp_pkg::TYPE_ERROR;
            8'd43:   t = rrsp_pkg::TYPE_STATUS;
            8'd58:   t = rrsp_pkg::TYPE_INTEGER;
            8'd44:   t = rrsp_pkg::TYPE_DOUBLE;
            8'd95:   t = rrsp_pkg::TYPE_NULL;
            8'd36:   t = rrsp_pkg::TYPE_BULK;
            8'd42:   t = rrsp_pkg::TYPE_ARRAY;
            8'd37:   t = rrsp_pkg::TYPE_MAP;
            8'd126:  t = rrsp_pkg::TYPE_SET;
            8'd35:   t = rrsp_pkg::TYPE_BOOL;
            8'd61:   t = rrsp_pkg::TYPE_VERBATIM;
            8'd62:   t = rrsp_pkg::TYPE_PUSH;
            8'd40:   t = rrsp_pkg::TYPE_BIGNUM;
            default: t = rrsp_pkg::TYPE_NONE;
        endcase
        return t;
    endfunction

    logic [3:0]            cur_type_reg,   cur_type_next;
    rrsp_pkg::line_phase_t line_phase_reg, line_phase_next;
    rrsp_pkg::bulk_phase_t bulk_phase_reg, bulk_phase_next;
    rrsp_pkg::agg_phase_t  agg_phase_reg,  agg_phase_next;
    logic [BLB-1:0]        bulk_len_reg,   bulk_len_next;
    logic [BLB-1:0]        bulk_pos_reg,   bulk_pos_next;
    logic [ELB-1:0]        elem_left_reg,  elem_left_next;
    logic [31:0]           replies_reg,    replies_next;
    logic                  fault_reg,      fault_next;
    logic [1:0]            held_status_reg, held_status_next;
    logic [2:0]            held_kind_reg,   held_kind_next;

    logic                  is_digit;
    logic [3:0]            digit;

    // Step results of the line and bulk sub-parsers from the current state.
    logic [2:0]            line_r;
    rrsp_pkg::line_phase_t line_phase_ln;
    logic [2:0]            bulk_r;
    rrsp_pkg::bulk_phase_t bulk_phase_bn;
    logic [BLB-1:0]        bulk_len_bn;
    logic [BLB-1:0]        bulk_pos_bn;
    logic [BPB-1:0]        bulk_len_ext;
    logic [BPB-1:0]        bulk_len_v;
    logic [BLB:0]          bulk_pos_inc;

    logic [EPB-1:0]        elem_ext;
    logic [EPB-1:0]        elem_v;
    logic [ELB-1:0]        elem_dec;

    assign is_digit = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
    assign digit    = byte_in[3:0];

    // Line replies and line elements: end at CR LF, a stray CR rescans.
    always_comb
    begin
        line_r        = rrsp_pkg::STEP_BUSY;
        line_phase_ln = (byte_in == CHAR_CR) ? rrsp_pkg::LINE_CR_SEEN : rrsp_pkg::LINE_SEEK_CR;
        if ((line_phase_reg == rrsp_pkg::LINE_CR_SEEN) && (byte_in == CHAR_LF))
        begin
            line_r        = rrsp_pkg::STEP_DONE;
            line_phase_ln = rrsp_pkg::LINE_SEEK_CR;
        end
    end

    // Bulk replies and bulk elements: decimal length, data, then CR LF.
    always_comb
    begin
        bulk_len_ext  = {{(BPB-BLB){1'b0}}, bulk_len_reg};
        bulk_len_v    = (bulk_len_ext << 3) + (bulk_len_ext << 1) + {{(BPB-4){1'b0}}, digit};
        bulk_pos_inc  = {1'b0, bulk_pos_reg} + {{BLB{1'b0}}, 1'b1};
        bulk_r        = rrsp_pkg::STEP_BUSY;
        bulk_phase_bn = bulk_phase_reg;
        bulk_len_bn   = bulk_len_reg;
        bulk_pos_bn   = bulk_pos_reg;
        unique case (bulk_phase_reg)
            rrsp_pkg::BULK_LEN:
            begin
                if (is_digit)
                begin
                    if (bulk_len_v > {{(BPB-BLB){1'b0}}, cfg.max_bulk_len})
                    begin
                        bulk_r = rrsp_pkg::ERR_BULK_TOO_LONG;
                    end
                    else
                    begin
                        bulk_len_bn = bulk_len_v[BLB-1:0];
                    end
                end
                else if (byte_in == CHAR_CR)
                begin
                    bulk_phase_bn = rrsp_pkg::BULK_LEN_LF;
                end
                else
                begin
                    bulk_r = rrsp_pkg::ERR_BULK_LEN_END;
                end
            end
            rrsp_pkg::BULK_LEN_LF:
            begin
                if (byte_in != CHAR_LF)
                begin
                    bulk_r = rrsp_pkg::ERR_BULK_LEN_END;
                end
                else
                begin
                    bulk_pos_bn = '0;
                    // An empty bulk goes straight to its trailing CR LF.
                    bulk_phase_bn = (bulk_len_reg == '0) ? rrsp_pkg::BULK_DATA_CR
                                                         : rrsp_pkg::BULK_DATA;
                end
            end
            rrsp_pkg::BULK_DATA:
            begin
                bulk_pos_bn = bulk_pos_inc[BLB-1:0];
                if (bulk_pos_inc >= {1'b0, bulk_len_reg})
                begin
                    bulk_phase_bn = rrsp_pkg::BULK_DATA_CR;
                end
            end
            rrsp_pkg::BULK_DATA_CR:
            begin
                if (byte_in != CHAR_CR)
                begin
                    bulk_r = rrsp_pkg::ERR_BULK_DATA_END;
                end
                else
                begin
                    bulk_phase_bn = rrsp_pkg::BULK_DATA_LF;
                end
            end
            rrsp_pkg::BULK_DATA_LF:
            begin
                if (byte_in != CHAR_LF)
                begin
                    bulk_r = rrsp_pkg::ERR_BULK_DATA_END;
                end
                else
                begin
                    bulk_phase_bn = rrsp_pkg::BULK_LEN;
                    bulk_r        = rrsp_pkg::STEP_DONE;
                end
            end
            default:
            begin
                bulk_phase_bn = rrsp_pkg::BULK_LEN;
            end
        endcase
    end

    // Top-level decode: type byte, then the sub-parser the type calls for.
    always_comb
    begin
        logic [2:0] r;
        logic [1:0] st;
        logic [2:0] kind;
        logic [7:0] err_b;
        logic [3:0] t;
        logic [3:0] shown;

        cur_type_next    = cur_type_reg;
        line_phase_next  = line_phase_reg;
        bulk_phase_next  = bulk_phase_reg;
        agg_phase_next   = agg_phase_reg;
        bulk_len_next    = bulk_len_reg;
        bulk_pos_next    = bulk_pos_reg;
        elem_left_next   = elem_left_reg;
        replies_next     = replies_reg;
        fault_next       = fault_reg;
        held_status_next = held_status_reg;
        held_kind_next   = held_kind_reg;

        elem_ext = {{(EPB-ELB){1'b0}}, elem_left_reg};
        elem_v   = (elem_ext << 3) + (elem_ext << 1) + {{(EPB-4){1'b0}}, digit};
        elem_dec = elem_left_reg - {{(ELB-1){1'b0}}, 1'b1};

        r     = rrsp_pkg::STEP_BUSY;
        st    = rrsp_pkg::ST_BUSY;
        kind  = rrsp_pkg::ERR_NONE;
        err_b = 8'd0;
        t     = decode_type(byte_in);

        if (fault_reg)
        begin
            st   = held_status_reg;
            kind = held_kind_reg;
        end
        else if (cur_type_reg == rrsp_pkg::TYPE_NONE)
        begin
            if (t == rrsp_pkg::TYPE_NONE)
            begin
                st               = rrsp_pkg::ST_FAULT;
                kind             = rrsp_pkg::ERR_BAD_TYPE;
                err_b            = byte_in;
                fault_next       = 1'b1;
                held_status_next = rrsp_pkg::ST_FAULT;
                held_kind_next   = rrsp_pkg::ERR_BAD_TYPE;
            end
            else
            begin
                cur_type_next   = t;
                line_phase_next = rrsp_pkg::LINE_SEEK_CR;
                bulk_phase_next = rrsp_pkg::BULK_LEN;
                agg_phase_next  = rrsp_pkg::AGG_COUNT;
                bulk_len_next   = '0;
                bulk_pos_next   = '0;
                elem_left_next  = '0;
            end
        end
        else
        begin
            case (cur_type_reg)
                rrsp_pkg::TYPE_BULK, rrsp_pkg::TYPE_VERBATIM:
                begin
                    r               = bulk_r;
                    bulk_phase_next = bulk_phase_bn;
                    bulk_len_next   = bulk_len_bn;
                    bulk_pos_next   = bulk_pos_bn;
                end
                rrsp_pkg::TYPE_ARRAY, rrsp_pkg::TYPE_MAP, rrsp_pkg::TYPE_SET,
                rrsp_pkg::TYPE_PUSH:
                begin
                    unique case (agg_phase_reg)
                        rrsp_pkg::AGG_COUNT:
                        begin
                            if (is_digit)
                            begin
                                if (elem_v > {{(EPB-CNB){1'b0}}, cfg.max_array_count})
                                begin
                                    r = rrsp_pkg::ERR_COUNT_LARGE;
                                end
                                else
                                begin
                                    elem_left_next = elem_v[ELB-1:0];
                                end
                            end
                            else if (byte_in == CHAR_CR)
                            begin
                                agg_phase_next = rrsp_pkg::AGG_COUNT_LF;
                            end
                            else
                            begin
                                r = rrsp_pkg::ERR_COUNT_END;
                            end
                        end
                        rrsp_pkg::AGG_COUNT_LF:
                        begin
                            if (byte_in != CHAR_LF)
                            begin
                                r = rrsp_pkg::ERR_COUNT_END;
                            end
                            else if (elem_left_reg == '0)
                            begin
                                r = rrsp_pkg::STEP_DONE;
                            end
                            else
                            begin
                                // A map of N entries carries 2N elements.
                                if (cur_type_reg == rrsp_pkg::TYPE_MAP)
                                begin
                                    elem_left_next = {elem_left_reg[ELB-2:0], 1'b0};
                                end
                                agg_phase_next = rrsp_pkg::AGG_HEADER;
                            end
                        end
                        rrsp_pkg::AGG_HEADER:
                        begin
                            if (byte_in == CHAR_DOLLAR)
                            begin
                                bulk_phase_next = rrsp_pkg::BULK_LEN;
                                bulk_len_next   = '0;
                                bulk_pos_next   = '0;
                                agg_phase_next  = rrsp_pkg::AGG_BULK;
                            end
                            else if ((byte_in == CHAR_COLON) || (byte_in == CHAR_COMMA) ||
                                     (byte_in == CHAR_UNDER) || (byte_in == CHAR_HASH) ||
                                     (byte_in == CHAR_LPAREN))
                            begin
                                line_phase_next = rrsp_pkg::LINE_SEEK_CR;
                                agg_phase_next  = rrsp_pkg::AGG_LINE;
                            end
                            else
                            begin
                                r = rrsp_pkg::ERR_ELEM_HEADER;
                            end
                        end
                        rrsp_pkg::AGG_BULK:
                        begin
                            bulk_phase_next = bulk_phase_bn;
                            bulk_len_next   = bulk_len_bn;
                            bulk_pos_next   = bulk_pos_bn;
                            r               = bulk_r;
                            if (bulk_r == rrsp_pkg::STEP_DONE)
                            begin
                                elem_left_next = elem_dec;
                                if (elem_dec != '0)
                                begin
                                    r              = rrsp_pkg::STEP_BUSY;
                                    agg_phase_next = rrsp_pkg::AGG_HEADER;
                                end
                            end
                        end
                        rrsp_pkg::AGG_LINE:
                        begin
                            line_phase_next = line_phase_ln;
                            r               = line_r;
                            if (line_r == rrsp_pkg::STEP_DONE)
                            begin
                                elem_left_next = elem_dec;
                                if (elem_dec != '0)
                                begin
                                    r              = rrsp_pkg::STEP_BUSY;
                                    agg_phase_next = rrsp_pkg::AGG_HEADER;
                                end
                            end
                        end
                        default:
                        begin
                            agg_phase_next = rrsp_pkg::AGG_COUNT;
                        end
                    endcase
                end
                default:
                begin
                    r               = line_r;
                    line_phase_next = line_phase_ln;
                end
            endcase

            if (r == rrsp_pkg::STEP_DONE)
            begin
                if (cur_type_reg == rrsp_pkg::TYPE_ERROR)
                begin
                    // A server error reply ends the stream like a fault, uncounted.
                    st               = rrsp_pkg::ST_SERVER_ERR;
                    fault_next       = 1'b1;
                    held_status_next = rrsp_pkg::ST_SERVER_ERR;
                    held_kind_next   = rrsp_pkg::ERR_NONE;
                end
                else
                begin
                    st           = rrsp_pkg::ST_COMPLETE;
                    replies_next = replies_reg + 32'd1;
                end
            end
            else if (r != rrsp_pkg::STEP_BUSY)
            begin
                st               = rrsp_pkg::ST_FAULT;
                kind             = r;
                err_b            = byte_in;
                fault_next       = 1'b1;
                held_status_next = rrsp_pkg::ST_FAULT;
                held_kind_next   = r;
            end
        end

        shown = cur_type_next;
        if (st == rrsp_pkg::ST_COMPLETE)
        begin
            cur_type_next = rrsp_pkg::TYPE_NONE;
        end

        result.status      = st;
        result.error_kind  = kind;
        result.reply_type  = shown;
        result.error_byte  = err_b;
        result.reply_count = replies_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_type_reg    <= rrsp_pkg::TYPE_NONE;
            line_phase_reg  <= rrsp_pkg::LINE_SEEK_CR;
            bulk_phase_reg  <= rrsp_pkg::BULK_LEN;
            agg_phase_reg   <= rrsp_pkg::AGG_COUNT;
            bulk_len_reg    <= '0;
            bulk_pos_reg    <= '0;
            elem_left_reg   <= '0;
            replies_reg     <= '0;
            fault_reg       <= 1'b0;
            held_status_reg <= rrsp_pkg::ST_BUSY;
            held_kind_reg   <= rrsp_pkg::ERR_NONE;
        end
        else if (take)
        begin
            cur_type_reg    <= cur_type_next;
            line_phase_reg  <= line_phase_next;
            bulk_phase_reg  <= bulk_phase_next;
            agg_phase_reg   <= agg_phase_next;
            bulk_len_reg    <= bulk_len_next;
            bulk_pos_reg    <= bulk_pos_next;
            elem_left_reg   <= elem_left_next;
            replies_reg     <= replies_next;
            fault_reg       <= fault_next;
            held_status_reg <= held_status_next;
            held_kind_reg   <= held_kind_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rrsp_out_stage.sv
// Result register of the RESP reply parser: one status item waiting for transfer.
// Depends on rrsp_pkg for the result struct.
`default_nettype none

module rrsp_out_stage (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire rrsp_pkg::result_t result,
    output logic             out_free,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rrsp_pkg::result_t out_data
);

    logic              valid_reg;
    logic              valid_next;
    rrsp_pkg::result_t data_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> src/resp_reply_stream_parser_unit.sv
// Top level of the RESP2/RESP3 reply stream parser: one status item per reply byte.
// Each byte passes the input register, and its status is then held in the result register
// and presented from there until its transfer.
// Throughput: one byte per cycle, set by the single decode pass between the
// input register and the result register; both stall only on out_ready.
// Reset (rst_n, asynchronous) empties both registers, clears the parser state
// and the sticky error, and loads the limit registers with their defaults.
// Depends on rrsp_pkg, rrsp_cfg_regs, rrsp_in_stage, rrsp_parse_core, rrsp_out_stage.
`default_nettype none

module resp_reply_stream_parser_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [rrsp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rrsp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          byte_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               status,
    output logic [2:0]                               error_kind,
    output logic [3:0]                               reply_type,
    output logic [7:0]                               error_byte,
    output logic [31:0]                              reply_count
);

    rrsp_pkg::cfg_t    cfg;
    rrsp_pkg::result_t result;
    rrsp_pkg::result_t out_data;
    logic              take;
    logic              out_free;
    logic [7:0]        byte_held;

    rrsp_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    rrsp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .out_free   (out_free),
        .take       (take),
        .byte_out   (byte_held)
    );

    rrsp_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .byte_in (byte_held),
        .cfg     (cfg),
        .result  (result)
    );

    rrsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign status      = out_data.status;
    assign error_kind  = out_data.error_kind;
    assign reply_type  = out_data.reply_type;
    assign error_byte  = out_data.error_byte;
    assign reply_count = out_data.reply_count;

    // An empty result register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low while the result register is empty");

    // A protocol fault always names its kind.
    a_fault_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == rrsp_pkg::ST_FAULT)) |->
            (error_kind != rrsp_pkg::ERR_NONE))
        else $error("protocol fault reported without an error kind");

    // Only a fault status carries an error kind or a faulting byte.
    a_kind_only_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((error_kind != rrsp_pkg::ERR_NONE) || (error_byte != 8'd0))) |->
            (status == rrsp_pkg::ST_FAULT))
        else $error("error kind or byte shown outside a fault");

    // A completed reply always has a reply type.
    a_complete_has_type: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == rrsp_pkg::ST_COMPLETE)) |->
            (reply_type != rrsp_pkg::TYPE_NONE))
        else $error("reply completed without a reply type");

endmodule

`default_nettype wire
